// File: sv/vpt_pkg.sv
package vpt_pkg;

	localparam int Q_W        = 32;
	localparam int FRAC_W     = 16;
	localparam int CFG_W      = 64;
	localparam int NUM_REGS   = 8;
	localparam int IDX_W      = 4;
	localparam int NUMER_W    = Q_W + FRAC_W;
	localparam int SIZE_MAX   = 4096;
	localparam int VIEW_WIDTH_DEF  = 128;
	localparam int VIEW_HEIGHT_DEF = 128;

	localparam logic [CFG_W-1:0] COEF_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

endpackage

// File: sv/vpt_div.sv
module vpt_div #(
	parameter int NUM_W = vpt_pkg::NUMER_W,
	parameter int DEN_W = vpt_pkg::Q_W,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic [NUM_W-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [TAG_W-1:0] tag_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_step
		logic [DEN_W-1:0] r_src;
		logic [NUM_W-1:0] nq_src;
		logic [DEN_W-1:0] d_src;
		logic [TAG_W-1:0] t_src;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign r_src  = '0;
			assign nq_src = num;
			assign d_src  = den;
			assign t_src  = tag_in;
		end else begin : g_next
			assign r_src  = rem_s[i-1];
			assign nq_src = nq_s[i-1];
			assign d_src  = den_s[i-1];
			assign t_src  = tag_s[i-1];
		end

		assign trial = {r_src, nq_src[NUM_W-1]};
		assign ge    = trial >= {1'b0, d_src};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (en) begin
				tag_s[i] <= t_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DEN_W'(trial - {1'b0, d_src}) : trial[DEN_W-1:0];
				nq_s[i]  <= {nq_src[NUM_W-2:0], ge};
				den_s[i] <= d_src;
			end
		end
	end

	assign quo     = nq_s[NUM_W-1];
	assign tag_out = tag_s[NUM_W-1];

endmodule

// File: sv/vertex_perspective_transform.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | vertex_x, vertex_y, vertex_z
// out     | output    | out_valid/out_ready | screen_x, screen_y, depth
// cfg     | input     | cfg_we              | cfg_index, cfg_data
// One vertex enters per cycle while the output is not held; the path has 3 transform stages, 48 divider
// stages in the bit-per-stage divider, 2 viewport stages and an output register.
// Vertices with w zero or depth at or below zero leave a bubble and no beat.
// A held output beat freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads the identity matrix.
module vertex_perspective_transform #(
	parameter int VIEW_WIDTH  = vpt_pkg::VIEW_WIDTH_DEF,
	parameter int VIEW_HEIGHT = vpt_pkg::VIEW_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [vpt_pkg::IDX_W-1:0]   cfg_index,
	input  logic [vpt_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [31:0]          vertex_x,
	input  logic signed [31:0]          vertex_y,
	input  logic signed [31:0]          vertex_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          screen_x,
	output logic signed [31:0]          screen_y,
	output logic signed [31:0]          depth
);

	localparam int NW   = vpt_pkg::NUMER_W;
	localparam int SZ_W = $clog2(vpt_pkg::SIZE_MAX + 1);
	localparam int ND_W = NW + 2;
	localparam int PR_W = ND_W + SZ_W + 1;
	localparam logic signed [SZ_W:0] WSZ = (SZ_W+1)'(VIEW_WIDTH);
	localparam logic signed [SZ_W:0] HSZ = (SZ_W+1)'(VIEW_HEIGHT);

	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		if (v > 80'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -80'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	logic [vpt_pkg::CFG_W-1:0] coef_q [vpt_pkg::NUM_REGS];
	logic signed [31:0]        cf     [4][4];
	logic signed [31:0]        vin    [3];
	logic                      en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= vpt_pkg::COEF_RESET;
		end else if (cfg_we && cfg_index < vpt_pkg::IDX_W'(vpt_pkg::NUM_REGS)) begin
			coef_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				cf[r][c] = coef_q[r*2 + c/2][(c%2)*32 +: 32];
			end
		end
	end

	assign vin[0] = vertex_x;
	assign vin[1] = vertex_y;
	assign vin[2] = vertex_z;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// products
	logic signed [63:0] p_s1 [4][4];
	logic               v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					p_s1[r][c] <= cf[r][c] * vin[c];
				end
				p_s1[r][3] <= 64'(cf[r][3]) <<< 16;
			end
		end
	end

	// row sums
	logic signed [31:0] clip_d  [4];
	logic signed [31:0] clip_s2 [4];
	logic               v_s2;

	always_comb begin
		logic signed [65:0] acc;
		for (int r = 0; r < 4; r++) begin
			acc = 66'(p_s1[r][0]) + 66'(p_s1[r][1]) + 66'(p_s1[r][2]) + 66'(p_s1[r][3]);
			clip_d[r] = sat32(80'(acc >>> 16));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip_s2 <= clip_d;
		end
	end

	// divider operands
	logic [NW-1:0] num_s3 [3];
	logic [31:0]   den_s3;
	logic [2:0]    sgn_s3;
	logic          live_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s3 <= 1'b0;
		end else if (en) begin
			live_s3 <= v_s2 && clip_s2[3] != '0;
		end
	end

	always_ff @(posedge clk) begin
		logic [NW-1:0] nm;
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				nm = {clip_s2[c], 16'h0000};
				num_s3[c] <= clip_s2[c][31] ? NW'(-nm) : nm;
				sgn_s3[c] <= clip_s2[c][31] ^ clip_s2[3][31];
			end
			den_s3 <= clip_s2[3][31] ? 32'(-clip_s2[3]) : clip_s2[3];
		end
	end

	logic [NW-1:0] qx, qy, qz;
	logic          sx_tag, sy_tag;
	logic [1:0]    z_tag;

	vpt_div #(.NUM_W(NW), .DEN_W(32), .TAG_W(1)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .num(num_s3[0]), .den(den_s3),
		.tag_in(sgn_s3[0]), .quo(qx), .tag_out(sx_tag)
	);

	vpt_div #(.NUM_W(NW), .DEN_W(32), .TAG_W(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .num(num_s3[1]), .den(den_s3),
		.tag_in(sgn_s3[1]), .quo(qy), .tag_out(sy_tag)
	);

	vpt_div #(.NUM_W(NW), .DEN_W(32), .TAG_W(2)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en), .num(num_s3[2]), .den(den_s3),
		.tag_in({live_s3, sgn_s3[2]}), .quo(qz), .tag_out(z_tag)
	);

	// signed quotients, x and y shifted by +1.0 so [-1,1] maps to [0,2]
	logic signed [ND_W-1:0] nx_s4, ny_s4;
	logic signed [NW:0]     nz_s4;
	logic                   live_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s4 <= 1'b0;
		end else if (en) begin
			live_s4 <= z_tag[1] && !z_tag[0] && qz != '0;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [NW:0] tx, ty;
		if (en) begin
			tx = sx_tag ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
			ty = sy_tag ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
			nx_s4 <= ND_W'(tx) + ND_W'(65536);
			ny_s4 <= ND_W'(ty) + ND_W'(65536);
			nz_s4 <= $signed({1'b0, qz});
		end
	end

	// viewport scale
	logic signed [PR_W-1:0] px_s5, py_s5;
	logic signed [31:0]     nz_s5;
	logic                   live_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s5 <= 1'b0;
		end else if (en) begin
			live_s5 <= live_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5 <= PR_W'(nx_s4) * PR_W'(WSZ);
			py_s5 <= PR_W'(ny_s4) * PR_W'(HSZ);
			nz_s5 <= sat32(80'(nz_s4));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= live_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			screen_x <= sat32(80'(px_s5 >>> 1));
			screen_y <= sat32(80'(py_s5 >>> 1));
			depth    <= nz_s5;
		end
	end

endmodule
